### hdl/abl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_pkg: shared types and constants of the audio block level meter
// Widths, register indexes, reset values and the controller/datapath
// command and status records.
// ----------------------------------------------------------------------------
package abl_pkg;

   localparam int BLOCK_SAMPLES_DEF = 128;
   localparam int SAMPLE_W          = 16;
   localparam int MAG_MAX           = 32768;
   localparam int LEVEL_W           = 7;
   localparam int FS_W              = 16;
   localparam int DIVR_W            = 7;
   localparam int DEN_W             = 16;
   localparam int PCT_NUM_W         = 23;
   localparam int CSR_INDEX_W       = 8;
   localparam int CSR_DATA_W        = 16;

   localparam logic [LEVEL_W-1:0] LEVEL_CAP = 7'd100;
   localparam logic [LEVEL_W-1:0] PCT_SCALE = 7'd100;

   localparam logic [FS_W-1:0]   AVG_FS_RESET   = 16'd1000;
   localparam logic [FS_W-1:0]   PEAK_FS_RESET  = 16'd4000;
   localparam logic [DIVR_W-1:0] RISE_DIV_RESET = 7'd4;
   localparam logic [DIVR_W-1:0] FALL_DIV_RESET = 7'd8;

   localparam logic [CSR_INDEX_W-1:0] CSR_AVG_FS   = 8'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PEAK_FS  = 8'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_RISE_DIV = 8'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_FALL_DIV = 8'd3;

   typedef enum logic [1:0] {
      DIV_MEAN,
      DIV_AVG,
      DIV_PEAK,
      DIV_STEP
   } div_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_AVG_GO,
      ST_AVG_WAIT,
      ST_PEAK_GO,
      ST_PEAK_WAIT,
      ST_STEP_GO,
      ST_STEP_WAIT,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic        sample_take;
      logic        div_start;
      logic        div_load;
      div_sel_type div_sel;
      logic        finish;
   } cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_busy;
   } status_type;

endpackage
`default_nettype wire

### hdl/abl_divider.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_divider: restoring unsigned divider
// One quotient bit per cycle; done pulses for one cycle with the quotient.
// ----------------------------------------------------------------------------
module abl_divider #(
   parameter int NUM_W = abl_pkg::PCT_NUM_W,
   parameter int DEN_W = abl_pkg::DEN_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [NUM_W-1:0] num,
   input  wire logic [DEN_W-1:0] den,
   output logic      [NUM_W-1:0] quot,
   output logic                  done
);

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic [NUM_W-1:0] num_ff, num_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;

   logic [DEN_W:0]   trial;
   logic [DEN_W:0]   diff;

   always_comb begin
      trial   = {rem_ff, num_ff[NUM_W-1]};
      diff    = trial - {1'b0, den_ff};
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         num_in  = num;
         rem_in  = '0;
         den_in  = den;
         cnt_in  = CNT_W'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract when no borrow, else keep the shifted remainder
         if (!diff[DEN_W]) begin
            rem_in = diff[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b1};
         end else begin
            rem_in = trial[DEN_W-1:0];
            num_in = {num_ff[NUM_W-2:0], 1'b0};
         end
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign quot = num_ff;
   assign done = done_ff;

`ifndef SYNTHESIS
   a_rem_below_den: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> (rem_ff < den_ff))
      else $error("divider remainder not below divisor");
`endif

endmodule
`default_nettype wire

### hdl/abl_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_datapath: accumulators, config registers, scaling and level update
// Runs the shared divider on the operand set the controller selects.
// ----------------------------------------------------------------------------
module abl_datapath #(
   parameter int BLOCK_SAMPLES = abl_pkg::BLOCK_SAMPLES_DEF
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire abl_pkg::cmd_type                      cmd,
   output abl_pkg::status_type                        status,
   input  wire logic signed [abl_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic             [abl_pkg::LEVEL_W-1:0]    rsp_level,
   output logic             [abl_pkg::SAMPLE_W-1:0]   rsp_block_peak,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic        [abl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [abl_pkg::CSR_DATA_W-1:0] csr_data
);

   localparam int CNT_W = $clog2(BLOCK_SAMPLES + 1);
   localparam int SUM_W = $clog2(BLOCK_SAMPLES * abl_pkg::MAG_MAX + 1);
   localparam int NUM_W = (SUM_W > abl_pkg::PCT_NUM_W) ? SUM_W : abl_pkg::PCT_NUM_W;
   localparam int SW    = abl_pkg::SAMPLE_W;
   localparam int LW    = abl_pkg::LEVEL_W;
   localparam int DW    = abl_pkg::DEN_W;

   // config registers
   logic [abl_pkg::FS_W-1:0]   avg_fs_ff, avg_fs_in;
   logic [abl_pkg::FS_W-1:0]   peak_fs_ff, peak_fs_in;
   logic [abl_pkg::DIVR_W-1:0] rise_div_ff, rise_div_in;
   logic [abl_pkg::DIVR_W-1:0] fall_div_ff, fall_div_in;

   // block state
   logic [SUM_W-1:0] sum_ff, sum_in;
   logic [SW-1:0]    peak_ff, peak_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [LW-1:0]    level_ff, level_in;

   // per-block results
   logic [SW-1:0]    mean_ff, mean_in;
   logic [LW-1:0]    avg_pct_ff, avg_pct_in;
   logic [LW-1:0]    peak_pct_ff, peak_pct_in;
   logic [LW-1:0]    step_ff, step_in;

   // output register
   logic             rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0]    rsp_level_ff, rsp_level_in;
   logic [SW-1:0]    rsp_peak_ff, rsp_peak_in;

   logic [SW-1:0]                  mag;
   logic                           has_room;
   logic [SW-1:0]                  mul_op;
   logic [abl_pkg::PCT_NUM_W-1:0]  prod;
   logic [LW-1:0]                  target;
   logic                           rising;
   logic [LW-1:0]                  diff;
   logic [abl_pkg::DIVR_W-1:0]     divisor;
   logic [LW-1:0]                  step_eff;
   logic [LW-1:0]                  level_next;
   logic [LW-1:0]                  pct_cap;
   logic [NUM_W-1:0]               div_num;
   logic [DW-1:0]                  div_den;
   logic [NUM_W-1:0]               div_quot;
   logic                           div_done;

   abl_divider #(
      .NUM_W (NUM_W),
      .DEN_W (DW)
   ) u_divider (
      .clock (clock),
      .reset (reset),
      .start (cmd.div_start),
      .num   (div_num),
      .den   (div_den),
      .quot  (div_quot),
      .done  (div_done)
   );

   always_comb begin
      mag      = req_sample[SW-1] ? SW'(-req_sample) : SW'(req_sample);
      has_room = cnt_ff < CNT_W'(BLOCK_SAMPLES);

      mul_op = (cmd.div_sel == abl_pkg::DIV_PEAK) ? peak_ff : mean_ff;
      prod   = abl_pkg::PCT_NUM_W'(mul_op) * abl_pkg::PCT_NUM_W'(abl_pkg::PCT_SCALE);

      target  = (avg_pct_ff > peak_pct_ff) ? avg_pct_ff : peak_pct_ff;
      rising  = target > level_ff;
      diff    = rising ? (target - level_ff) : (level_ff - target);
      divisor = rising ? rise_div_ff : fall_div_ff;
      if (divisor == '0) begin
         divisor = abl_pkg::DIVR_W'(1);
      end

      step_eff = (step_ff == '0) ? LW'(1) : step_ff;
      if (rising) begin
         level_next = level_ff + step_eff;
      end else if (target < level_ff) begin
         level_next = level_ff - step_eff;
      end else begin
         level_next = level_ff;
      end

      pct_cap = (div_quot > NUM_W'(abl_pkg::LEVEL_CAP)) ? abl_pkg::LEVEL_CAP : div_quot[LW-1:0];

      case (cmd.div_sel)
         abl_pkg::DIV_MEAN: begin
            div_num = NUM_W'(sum_ff);
            div_den = DW'(cnt_ff);
         end
         abl_pkg::DIV_AVG: begin
            div_num = NUM_W'(prod);
            div_den = (avg_fs_ff == '0) ? DW'(1) : DW'(avg_fs_ff);
         end
         abl_pkg::DIV_PEAK: begin
            div_num = NUM_W'(prod);
            div_den = (peak_fs_ff == '0) ? DW'(1) : DW'(peak_fs_ff);
         end
         default: begin
            div_num = NUM_W'(diff);
            div_den = DW'(divisor);
         end
      endcase
   end

   always_comb begin
      avg_fs_in   = avg_fs_ff;
      peak_fs_in  = peak_fs_ff;
      rise_div_in = rise_div_ff;
      fall_div_in = fall_div_ff;
      if (csr_valid) begin
         case (csr_index)
            abl_pkg::CSR_AVG_FS:   avg_fs_in   = csr_data[abl_pkg::FS_W-1:0];
            abl_pkg::CSR_PEAK_FS:  peak_fs_in  = csr_data[abl_pkg::FS_W-1:0];
            abl_pkg::CSR_RISE_DIV: rise_div_in = csr_data[abl_pkg::DIVR_W-1:0];
            abl_pkg::CSR_FALL_DIV: fall_div_in = csr_data[abl_pkg::DIVR_W-1:0];
            default: ;
         endcase
      end

      sum_in       = sum_ff;
      peak_in      = peak_ff;
      cnt_in       = cnt_ff;
      level_in     = level_ff;
      mean_in      = mean_ff;
      avg_pct_in   = avg_pct_ff;
      peak_pct_in  = peak_pct_ff;
      step_in      = step_ff;
      rsp_level_in = rsp_level_ff;
      rsp_peak_in  = rsp_peak_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;

      // samples past capacity are dropped
      if (cmd.sample_take && has_room) begin
         sum_in = sum_ff + SUM_W'(mag);
         cnt_in = cnt_ff + CNT_W'(1);
         if (mag > peak_ff) begin
            peak_in = mag;
         end
      end

      if (cmd.div_load && div_done) begin
         case (cmd.div_sel)
            abl_pkg::DIV_MEAN: mean_in     = div_quot[SW-1:0];
            abl_pkg::DIV_AVG:  avg_pct_in  = pct_cap;
            abl_pkg::DIV_PEAK: peak_pct_in = pct_cap;
            default:           step_in     = div_quot[LW-1:0];
         endcase
      end

      if (cmd.finish) begin
         level_in     = level_next;
         rsp_level_in = level_next;
         rsp_peak_in  = peak_ff;
         rsp_valid_in = 1'b1;
         sum_in       = '0;
         peak_in      = '0;
         cnt_in       = '0;
      end
   end

   always_ff @(posedge clock) begin
      mean_ff      <= mean_in;
      avg_pct_ff   <= avg_pct_in;
      peak_pct_ff  <= peak_pct_in;
      step_ff      <= step_in;
      rsp_level_ff <= rsp_level_in;
      rsp_peak_ff  <= rsp_peak_in;
      if (reset) begin
         avg_fs_ff    <= abl_pkg::AVG_FS_RESET;
         peak_fs_ff   <= abl_pkg::PEAK_FS_RESET;
         rise_div_ff  <= abl_pkg::RISE_DIV_RESET;
         fall_div_ff  <= abl_pkg::FALL_DIV_RESET;
         sum_ff       <= '0;
         peak_ff      <= '0;
         cnt_ff       <= '0;
         level_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         avg_fs_ff    <= avg_fs_in;
         peak_fs_ff   <= peak_fs_in;
         rise_div_ff  <= rise_div_in;
         fall_div_ff  <= fall_div_in;
         sum_ff       <= sum_in;
         peak_ff      <= peak_in;
         cnt_ff       <= cnt_in;
         level_ff     <= level_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign status.div_done = div_done;
   assign status.out_busy = rsp_valid_ff & ~rsp_ready;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_level       = rsp_level_ff;
   assign rsp_block_peak  = rsp_peak_ff;
   assign csr_ready       = 1'b1;

`ifndef SYNTHESIS
   a_count_in_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(BLOCK_SAMPLES))
      else $error("sample count beyond block capacity");

   a_level_capped: assert property (@(posedge clock) disable iff (reset)
      level_ff <= abl_pkg::LEVEL_CAP)
      else $error("kept level above cap");
`endif

endmodule
`default_nettype wire

### hdl/abl_control.sv
`default_nettype none
// ----------------------------------------------------------------------------
// abl_control: block sequencer
// Accepts samples while idle; at a block end runs the four divisions in turn
// and hands the result to the output register.
// ----------------------------------------------------------------------------
module abl_control (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire logic                req_block_end,
   input  wire abl_pkg::status_type status,
   output abl_pkg::cmd_type         cmd
);

   abl_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in        = state_ff;
      req_ready       = 1'b0;
      cmd.sample_take = 1'b0;
      cmd.div_start   = 1'b0;
      cmd.div_load    = 1'b0;
      cmd.div_sel     = abl_pkg::DIV_MEAN;
      cmd.finish      = 1'b0;
      case (state_ff)
         abl_pkg::ST_IDLE: begin
            req_ready       = 1'b1;
            cmd.sample_take = req_valid;
            if (req_valid && req_block_end) begin
               state_in = abl_pkg::ST_MEAN_GO;
            end
         end
         abl_pkg::ST_MEAN_GO: begin
            cmd.div_start = 1'b1;
            state_in      = abl_pkg::ST_MEAN_WAIT;
         end
         abl_pkg::ST_MEAN_WAIT: begin
            cmd.div_load = 1'b1;
            if (status.div_done) begin
               state_in = abl_pkg::ST_AVG_GO;
            end
         end
         abl_pkg::ST_AVG_GO: begin
            cmd.div_sel   = abl_pkg::DIV_AVG;
            cmd.div_start = 1'b1;
            state_in      = abl_pkg::ST_AVG_WAIT;
         end
         abl_pkg::ST_AVG_WAIT: begin
            cmd.div_sel  = abl_pkg::DIV_AVG;
            cmd.div_load = 1'b1;
            if (status.div_done) begin
               state_in = abl_pkg::ST_PEAK_GO;
            end
         end
         abl_pkg::ST_PEAK_GO: begin
            cmd.div_sel   = abl_pkg::DIV_PEAK;
            cmd.div_start = 1'b1;
            state_in      = abl_pkg::ST_PEAK_WAIT;
         end
         abl_pkg::ST_PEAK_WAIT: begin
            cmd.div_sel  = abl_pkg::DIV_PEAK;
            cmd.div_load = 1'b1;
            if (status.div_done) begin
               state_in = abl_pkg::ST_STEP_GO;
            end
         end
         abl_pkg::ST_STEP_GO: begin
            cmd.div_sel   = abl_pkg::DIV_STEP;
            cmd.div_start = 1'b1;
            state_in      = abl_pkg::ST_STEP_WAIT;
         end
         abl_pkg::ST_STEP_WAIT: begin
            cmd.div_sel  = abl_pkg::DIV_STEP;
            cmd.div_load = 1'b1;
            if (status.div_done) begin
               state_in = abl_pkg::ST_FINISH;
            end
         end
         abl_pkg::ST_FINISH: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.finish = 1'b1;
               state_in   = abl_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = abl_pkg::ST_IDLE;
         end
      endcase
   end

`ifndef SYNTHESIS
   a_done_while_waiting: assert property (@(posedge clock) disable iff (reset)
      status.div_done |-> (state_ff == abl_pkg::ST_MEAN_WAIT ||
                           state_ff == abl_pkg::ST_AVG_WAIT ||
                           state_ff == abl_pkg::ST_PEAK_WAIT ||
                           state_ff == abl_pkg::ST_STEP_WAIT))
      else $error("division finished outside a wait state");
`endif

endmodule
`default_nettype wire

### hdl/audio_block_level_meter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// audio_block_level_meter: block level meter with rise/fall smoothing
// Sums absolute sample values and tracks the peak per block, then scales the
// mean and the peak to percent and moves a kept level toward the larger one.
// ----------------------------------------------------------------------------
// Usage:
//   req_*  : one signed 16-bit sample per request; req_block_end marks the
//            last sample of a block. Samples past BLOCK_SAMPLES in a block
//            are dropped, but the block end still closes the block.
//   rsp_*  : one result per block end: the smoothed level (0..100 percent)
//            and the block's peak absolute value.
//   csr_*  : register writes (0 mean full scale, 1 peak full scale,
//            2 rise divisor, 3 fall divisor); always ready, other indexes
//            are dropped. Write only while the block is idle.
//   Requests that do not end a block are taken back to back while idle.
//   A block end runs four divisions back to back on one shared restoring
//   divider of NUM_W bits (23 at the default capacity) before the result is
//   loaded; req_ready stays low meanwhile. The result then sits in the
//   output register.
//   Stall: while a result waits for rsp_ready, new samples are still taken;
//   the next block end holds its result until the register frees up.
//   Reset: clears the accumulators, the level and the output valid, and
//   loads the register defaults (1000, 4000, 4, 8).
// ----------------------------------------------------------------------------
module audio_block_level_meter #(
   parameter int BLOCK_SAMPLES = abl_pkg::BLOCK_SAMPLES_DEF
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic signed [abl_pkg::SAMPLE_W-1:0]    req_sample,
   input  wire logic                                   req_block_end,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic             [abl_pkg::LEVEL_W-1:0]     rsp_level,
   output logic             [abl_pkg::SAMPLE_W-1:0]    rsp_block_peak,
   input  wire logic                                   csr_valid,
   output logic                                        csr_ready,
   input  wire logic        [abl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic        [abl_pkg::CSR_DATA_W-1:0]  csr_data
);

   abl_pkg::cmd_type    cmd;
   abl_pkg::status_type status;

   // sequencer: request handshake and division order
   abl_control u_control (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_block_end (req_block_end),
      .status        (status),
      .cmd           (cmd)
   );

   // accumulators, registers, divider and output register
   abl_datapath #(
      .BLOCK_SAMPLES (BLOCK_SAMPLES)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_sample     (req_sample),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_block_peak (rsp_block_peak),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

endmodule
`default_nettype wire

### bench/tb_audio_block_level_meter.sv
// ----------------------------------------------------------------------------
// tb_audio_block_level_meter: self-checking bench for the block level meter
// Streams blocks of signed samples through the request channel, predicts the
// smoothed level and the block peak for every block end, and compares each
// reading on the response channel in order. Register settings are changed
// between phases while the meter is idle; both channels idle at random but in the last phase.
// ----------------------------------------------------------------------------
module tb_audio_block_level_meter;

   localparam int SAMPLE_W    = abl_pkg::SAMPLE_W;
   localparam int LEVEL_W     = abl_pkg::LEVEL_W;
   localparam int FS_W        = abl_pkg::FS_W;
   localparam int DIVR_W      = abl_pkg::DIVR_W;
   localparam int PCT_NUM_W   = abl_pkg::PCT_NUM_W;
   localparam int CSR_INDEX_W = abl_pkg::CSR_INDEX_W;
   localparam int CSR_DATA_W  = abl_pkg::CSR_DATA_W;
   localparam int MAG_MAX     = abl_pkg::MAG_MAX;

   localparam int BLOCK_CAP      = abl_pkg::BLOCK_SAMPLES_DEF;
   localparam int SETTLE_CYCLES  = 120;   // margin for a block end still in the divider
   localparam int STALL_LIMIT    = 4000;  // cycles with no handshake at all
   localparam int RSP_HOLD_CYCLES = 400;

   // Register indexes the meter must ignore.
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LOW = 8'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_TOP = 8'd255;

   // Idle schedule of the two channels.
   typedef enum int {
      IDLE_SENDER_LIGHT,
      IDLE_SENDER_HEAVY,
      IDLE_NONE
   } idle_mode_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       ends_block;
   } sample_req_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [SAMPLE_W-1:0] peak;
   } meter_reading_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                       req_valid     = 1'b0;
   logic                       req_ready;
   logic signed [SAMPLE_W-1:0] req_sample    = '0;
   logic                       req_block_end = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready     = 1'b0;
   logic [LEVEL_W-1:0]         rsp_level;
   logic [SAMPLE_W-1:0]        rsp_block_peak;
   logic                       csr_valid     = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_W-1:0]     csr_index     = '0;
   logic [CSR_DATA_W-1:0]      csr_data      = '0;

   audio_block_level_meter dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_block_end  (req_block_end),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_level      (rsp_level),
      .rsp_block_peak (rsp_block_peak),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // --------------------------------------------------------------------------
   // Level predictor: its own copy of the registers and the block state
   // --------------------------------------------------------------------------
   logic [FS_W-1:0]    mean_full_scale;
   logic [FS_W-1:0]    peak_full_scale;
   logic [DIVR_W-1:0]  rise_div;
   logic [DIVR_W-1:0]  fall_div;

   logic [PCT_NUM_W-1:0] block_sum;
   logic [SAMPLE_W-1:0]  block_peak_acc;
   logic [7:0]           block_fill;
   logic [LEVEL_W-1:0]   level_kept;

   sample_req_type    samples_to_send[$];
   meter_reading_type readings_due[$];

   idle_mode_type idle_mode = IDLE_SENDER_LIGHT;
   int mismatches    = 0;
   int samples_taken = 0;
   int readings_seen = 0;
   int reg_writes    = 0;
   int stall_cycles  = 0;
   int rsp_hold_left = 0;
   bit rsp_hold_done = 1'b0;

   function automatic int unsigned at_least_one(input int unsigned v);
      return (v == 0) ? 1 : v;
   endfunction

   function automatic int unsigned scale_to_percent(input int unsigned v,
                                                    input int unsigned full_scale);
      int unsigned pct;
      pct = (v * 100) / at_least_one(full_scale);
      return (pct > abl_pkg::LEVEL_CAP) ? abl_pkg::LEVEL_CAP : pct;
   endfunction

   // Fold one accepted sample into the block; close the block on its end flag.
   function automatic void predict_sample(input logic signed [SAMPLE_W-1:0] s,
                                          input logic ends_block);
      int                sv;
      int unsigned       mag, mean, target, step, lvl, nxt;
      meter_reading_type r;
      sv  = s;
      mag = (sv < 0) ? -sv : sv;
      if (block_fill < BLOCK_CAP) begin
         block_sum = block_sum + PCT_NUM_W'(mag);
         if (mag > block_peak_acc) block_peak_acc = SAMPLE_W'(mag);
         block_fill = block_fill + 8'd1;
      end
      if (!ends_block) return;
      mean   = (block_fill == 0) ? 0 : block_sum / block_fill;
      target = scale_to_percent(mean, mean_full_scale);
      if (scale_to_percent(block_peak_acc, peak_full_scale) > target)
         target = scale_to_percent(block_peak_acc, peak_full_scale);
      lvl = level_kept;
      if (target > lvl) begin
         step = (target - lvl) / at_least_one(rise_div);
         nxt  = lvl + ((step == 0) ? 1 : step);
      end else if (target < lvl) begin
         step = (lvl - target) / at_least_one(fall_div);
         nxt  = lvl - ((step == 0) ? 1 : step);
      end else begin
         nxt = lvl;
      end
      level_kept = LEVEL_W'(nxt);
      r.level = level_kept;
      r.peak  = block_peak_acc;
      readings_due.push_back(r);
      block_sum      = '0;
      block_peak_acc = '0;
      block_fill     = '0;
   endfunction

   function automatic void apply_reg_write(input logic [CSR_INDEX_W-1:0] idx,
                                           input logic [CSR_DATA_W-1:0] val);
      case (idx)
         abl_pkg::CSR_AVG_FS:   mean_full_scale = val;
         abl_pkg::CSR_PEAK_FS:  peak_full_scale = val;
         abl_pkg::CSR_RISE_DIV: rise_div        = val[DIVR_W-1:0];
         abl_pkg::CSR_FALL_DIV: fall_div        = val[DIVR_W-1:0];
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("MISMATCH @%0t: %s", $time, what);
   endtask

   function automatic int sender_idle_pct();
      case (idle_mode)
         IDLE_SENDER_LIGHT: return 32;
         IDLE_SENDER_HEAVY: return 45;
         default:           return 0;
      endcase
   endfunction

   function automatic int receiver_idle_pct();
      case (idle_mode)
         IDLE_SENDER_LIGHT: return 45;
         IDLE_SENDER_HEAVY: return 32;
         default:           return 0;
      endcase
   endfunction

   // --------------------------------------------------------------------------
   // Request driver: predict on each accepted request, then offer the next one
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : sample_driver
      sample_req_type nxt_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            predict_sample(req_sample, req_block_end);
            samples_taken++;
         end
         // Hold the current request until it is taken; only then advance.
         if (!req_valid || req_ready) begin
            if (samples_to_send.size() != 0 &&
                $urandom_range(0, 99) >= sender_idle_pct()) begin
               nxt_req = samples_to_send.pop_front();
               req_valid     <= 1'b1;
               req_sample    <= nxt_req.sample;
               req_block_end <= nxt_req.ends_block;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // --------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold in the no-idle phase so the
   // output register stays full and the next block end backs up the input.
   // --------------------------------------------------------------------------
   always @(posedge clock) begin : reading_sink
      if (reset) begin
         rsp_ready     <= 1'b0;
         rsp_hold_left = 0;
      end else if (rsp_hold_left > 0) begin
         rsp_hold_left--;
         rsp_ready <= 1'b0;
      end else if (idle_mode == IDLE_NONE && !rsp_hold_done && rsp_valid) begin
         rsp_hold_left = RSP_HOLD_CYCLES;
         rsp_hold_done = 1'b1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= receiver_idle_pct());
      end
   end

   // Compare each accepted reading with the oldest prediction.
   always @(posedge clock) begin : check_reading
      meter_reading_type due;
      if (!reset && rsp_valid && rsp_ready) begin
         readings_seen++;
         if (readings_due.size() == 0) begin
            report_mismatch($sformatf("reading with nothing due: level %0d peak %0d",
                                      rsp_level, rsp_block_peak));
         end else begin
            due = readings_due.pop_front();
            if (rsp_level !== due.level)
               report_mismatch($sformatf("level %0d, predicted %0d",
                                         rsp_level, due.level));
            if (rsp_block_peak !== due.peak)
               report_mismatch($sformatf("block peak %0d, predicted %0d",
                                         rsp_block_peak, due.peak));
         end
      end
   end

   // Watchdog: any handshake restarts the count.
   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // --------------------------------------------------------------------------
   // Stimulus helpers
   // --------------------------------------------------------------------------
   task automatic write_reg(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      apply_reg_write(idx, val);
      reg_writes++;
      csr_valid <= 1'b0;
   endtask

   // Wait until every queued request is taken and every reading has come back,
   // then let the divider finish anything still in flight.
   task automatic drain();
      do @(negedge clock);
      while (samples_to_send.size() != 0 || req_valid || readings_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic void queue_sample(input logic signed [SAMPLE_W-1:0] s,
                                        input logic ends_block);
      sample_req_type r;
      r.sample     = s;
      r.ends_block = ends_block;
      samples_to_send.push_back(r);
   endfunction

   function automatic logic signed [SAMPLE_W-1:0] draw_sample(input int amp);
      int v;
      case ($urandom_range(0, 19))
         0: return 16'sh8000;     // most negative: magnitude 32768
         1: return 16'sh7fff;
         default: ;
      endcase
      if (amp >= MAG_MAX) return SAMPLE_W'($urandom_range(0, 65535));
      v = int'($urandom_range(0, 2 * amp)) - amp;
      return SAMPLE_W'(v);
   endfunction

   function automatic void queue_block(input int len, input int amp);
      for (int i = 0; i < len; i++)
         queue_sample(draw_sample(amp), i == len - 1);
   endfunction

   // Blocks of random length and loudness; long ones may overrun the capacity.
   function automatic void queue_random_blocks(input int n_samples, input bit allow_long);
      int added, len, amp;
      added = 0;
      while (added < n_samples) begin
         case ($urandom_range(0, 99)) inside
            [0:5]:   len = allow_long ? $urandom_range(BLOCK_CAP - 8, BLOCK_CAP + 12) : 3;
            [6:30]:  len = 1;
            default: len = $urandom_range(2, 16);
         endcase
         case ($urandom_range(0, 4))
            0: amp = 0;
            1: amp = 200;
            2: amp = 2000;
            3: amp = 12000;
            default: amp = MAG_MAX;
         endcase
         queue_block(len, amp);
         added += len;
      end
   endfunction

   // --------------------------------------------------------------------------
   // Test sequence
   // --------------------------------------------------------------------------
   initial begin
      mean_full_scale = abl_pkg::AVG_FS_RESET;
      peak_full_scale = abl_pkg::PEAK_FS_RESET;
      rise_div        = abl_pkg::RISE_DIV_RESET;
      fall_div        = abl_pkg::FALL_DIV_RESET;
      block_sum       = '0;
      block_peak_acc  = '0;
      block_fill      = '0;
      level_kept      = '0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed: field extremes at the reset register values.
      @(negedge clock);
      idle_mode = IDLE_SENDER_LIGHT;
      queue_sample(16'sh8000, 1'b1);            // lone most-negative sample
      queue_sample(16'sh7fff, 1'b1);
      queue_sample(16'sd0, 1'b1);               // level starts to fall
      queue_sample(16'sd1, 1'b0);
      queue_sample(-16'sd1, 1'b0);
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7fff, 1'b0);
      queue_sample(16'sh8000, 1'b0);
      queue_sample(16'sh7fff, 1'b1);
      queue_sample(16'sd1000, 1'b0);            // mean exactly at full scale
      queue_sample(-16'sd1000, 1'b1);
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sd0, 1'b1);
      queue_sample(16'sd500, 1'b0);
      queue_sample(-16'sd499, 1'b1);
      // Exactly full, then one past capacity.
      queue_block(BLOCK_CAP, 2000);
      queue_block(BLOCK_CAP + 1, MAG_MAX);
      queue_random_blocks(100, 1'b1);
      drain();

      // Lowest full scales and divisors: every block snaps to its target.
      write_reg(abl_pkg::CSR_AVG_FS, 16'd1);
      write_reg(abl_pkg::CSR_PEAK_FS, 16'd1);
      write_reg(abl_pkg::CSR_RISE_DIV, 16'd1);
      write_reg(abl_pkg::CSR_FALL_DIV, 16'd1);
      write_reg(CSR_SPARE_LOW, 16'hffff);
      @(negedge clock);
      queue_random_blocks(90, 1'b1);
      drain();

      // Highest legal full scales and divisors.
      write_reg(abl_pkg::CSR_AVG_FS, 16'd32768);
      write_reg(abl_pkg::CSR_PEAK_FS, 16'd32768);
      write_reg(abl_pkg::CSR_RISE_DIV, 16'd64);
      write_reg(abl_pkg::CSR_FALL_DIV, 16'd64);
      @(negedge clock);
      idle_mode = IDLE_SENDER_HEAVY;
      queue_random_blocks(100, 1'b1);
      drain();

      // Zero registers read as one, divisor above 64, high data bits dropped.
      write_reg(abl_pkg::CSR_AVG_FS, 16'd0);
      write_reg(abl_pkg::CSR_PEAK_FS, 16'hffff);
      write_reg(abl_pkg::CSR_RISE_DIV, 16'hff80);
      write_reg(abl_pkg::CSR_FALL_DIV, 16'h007f);
      write_reg(CSR_SPARE_TOP, 16'ha5a5);
      @(negedge clock);
      queue_random_blocks(90, 1'b1);
      drain();

      // Random in-range settings; short blocks so the long hold backs up input.
      write_reg(abl_pkg::CSR_AVG_FS, CSR_DATA_W'($urandom_range(1, 32768)));
      write_reg(abl_pkg::CSR_PEAK_FS, CSR_DATA_W'($urandom_range(1, 32768)));
      write_reg(abl_pkg::CSR_RISE_DIV, CSR_DATA_W'($urandom_range(1, 64)));
      write_reg(abl_pkg::CSR_FALL_DIV, 16'hff00 | CSR_DATA_W'($urandom_range(1, 64)));
      @(negedge clock);
      idle_mode = IDLE_NONE;
      queue_random_blocks(100, 1'b0);
      drain();

      if (readings_due.size() != 0)
         report_mismatch($sformatf("%0d readings never arrived", readings_due.size()));
      $display("Run covered %0d samples and %0d block readings over %0d register writes,",
               samples_taken, readings_seen, reg_writes);
      $display("with both channels idling in turn and one long receiver hold.");
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
